FILE: src/dh_forward_kinematics_chain_core_defines.svh
// Assertion macros for the forward kinematics chain core.
`ifndef DH_FORWARD_KINEMATICS_CHAIN_CORE_DEFINES_SVH
`define DH_FORWARD_KINEMATICS_CHAIN_CORE_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define DHFK_ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");
`define DHFK_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define DHFK_ASSERT_IMPL(label, clk, rstn, ante, cons)
`define DHFK_ASSERT_NEXT(label, clk, rstn, ante, cons)
`endif
`endif

FILE: src/dhfk_pkg.sv
// ----------------------------------------------------------------------------
// dhfk_pkg
// Shared types and constants for the forward kinematics chain core.
// ----------------------------------------------------------------------------
`default_nettype none
package dhfk_pkg;
    localparam int MAX_STEPS = 24;
    localparam logic signed [33:0] ANG_PI      = 34'sd1686629713;
    localparam logic signed [33:0] ANG_HALF_PI = 34'sd843314856;
    localparam logic signed [33:0] CORDIC_K    = 34'sd652032874;
    localparam logic signed [31:0] Q_ONE       = 32'sd65536;

    typedef struct packed {
        logic               first_joint;
        logic signed [31:0] link_length;
        logic signed [31:0] link_offset;
        logic signed [16:0] theta;
        logic signed [15:0] alpha;
    } joint_t;

    function automatic logic signed [33:0] atan_entry(input logic [4:0] i);
        logic signed [33:0] r;
        case (i)
            5'd0: r = 34'sd421657428;
            5'd1: r = 34'sd248918915;
            5'd2: r = 34'sd131521918;
            5'd3: r = 34'sd66762579;
            5'd4: r = 34'sd33510843;
            5'd5: r = 34'sd16771758;
            5'd6: r = 34'sd8387925;
            5'd7: r = 34'sd4194219;
            5'd8: r = 34'sd2097141;
            5'd9: r = 34'sd1048575;
            default: r = 34'sd1 <<< (5'd29 - i);
        endcase
        return r;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
        logic signed [31:0] r;
        if (v > 66'sd2147483647) begin
            r = 32'sh7fffffff;
        end else if (v < -66'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction
endpackage
`default_nettype wire

FILE: src/dhfk_front.sv
// ----------------------------------------------------------------------------
// dhfk_front
// Accepts joint requests and places them in a two-entry queue.
// ----------------------------------------------------------------------------
`default_nettype none
module dhfk_front
    import dhfk_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic               s_first_joint,
    input  wire logic signed [31:0] s_link_length,
    input  wire logic signed [31:0] s_link_offset,
    input  wire logic signed [15:0] s_joint_angle,
    input  wire logic signed [15:0] s_home_angle,
    input  wire logic signed [15:0] s_link_twist,
    output logic                    q_valid,
    input  wire logic               q_ready,
    output joint_t                  q_data
);
    joint_t     mem_reg [2];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;
    joint_t     in_item;
    logic       push, pop;

    assign in_item.first_joint = s_first_joint;
    assign in_item.link_length = s_link_length;
    assign in_item.link_offset = s_link_offset;
    assign in_item.theta = 17'(s_joint_angle) + 17'(s_home_angle);
    assign in_item.alpha = s_link_twist;
    assign s_ready = (cnt_reg != 2'd2);
    assign q_valid = (cnt_reg != 2'd0);
    assign q_data  = mem_reg[rp_reg];
    assign push = s_valid && s_ready;
    assign pop  = q_valid && q_ready;

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wp_reg] <= in_item;
        end
        if (!aresetn) begin
            wp_reg <= 1'b0;
            rp_reg <= 1'b0;
            cnt_reg <= 2'd0;
        end else begin
            if (push) wp_reg <= ~wp_reg;
            if (pop) rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + 2'(push) - 2'(pop);
        end
    end
endmodule
`default_nettype wire

FILE: src/dhfk_cordic.sv
// ----------------------------------------------------------------------------
// dhfk_cordic
// Iterative CORDIC sine and cosine, one rotation step per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module dhfk_cordic
    import dhfk_pkg::*;
#(
    parameter int CORDIC_STEPS = 16
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               start,
    input  wire logic signed [16:0] angle,
    output logic                    done,
    output logic signed [31:0]      sin_out,
    output logic signed [31:0]      cos_out
);
    typedef enum logic [1:0] {ST_IDLE, ST_FOLD, ST_ROT, ST_FIN} state_t;
    state_t state_reg;
    logic signed [35:0] x_reg, y_reg, z_reg;
    logic flip_reg;
    logic [4:0] i_reg;
    logic signed [35:0] xs, ys, xr, yr;

    assign xs = x_reg >>> i_reg;
    assign ys = y_reg >>> i_reg;
    assign xr = (x_reg + 36'sd8192) >>> 14;
    assign yr = (y_reg + 36'sd8192) >>> 14;

    function automatic logic signed [31:0] clampu(input logic signed [35:0] v);
        logic signed [31:0] r;
        if (v > 36'sd65536) r = Q_ONE;
        else if (v < -36'sd65536) r = -Q_ONE;
        else r = v[31:0];
        return r;
    endfunction

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            done <= 1'b0;
        end else begin
            done <= 1'b0;
            case (state_reg)
                ST_IDLE: begin
                    if (start) begin
                        z_reg <= 36'(angle) <<< 16;
                        x_reg <= 36'(CORDIC_K);
                        y_reg <= '0;
                        flip_reg <= 1'b0;
                        i_reg <= 5'd0;
                        state_reg <= ST_FOLD;
                    end
                end
                ST_FOLD: begin
                    if (z_reg > 36'(ANG_HALF_PI)) begin
                        z_reg <= z_reg - 36'(ANG_PI);
                        flip_reg <= ~flip_reg;
                    end else if (z_reg < -36'(ANG_HALF_PI)) begin
                        z_reg <= z_reg + 36'(ANG_PI);
                        flip_reg <= ~flip_reg;
                    end
                    if (i_reg == 5'd3) begin
                        i_reg <= 5'd0;
                        state_reg <= ST_ROT;
                    end else begin
                        i_reg <= i_reg + 5'd1;
                    end
                end
                ST_ROT: begin
                    if (z_reg >= 0) begin
                        x_reg <= x_reg - ys;
                        y_reg <= y_reg + xs;
                        z_reg <= z_reg - 36'(atan_entry(i_reg));
                    end else begin
                        x_reg <= x_reg + ys;
                        y_reg <= y_reg - xs;
                        z_reg <= z_reg + 36'(atan_entry(i_reg));
                    end
                    if (i_reg == 5'(CORDIC_STEPS - 1)) state_reg <= ST_FIN;
                    else i_reg <= i_reg + 5'd1;
                end
                ST_FIN: begin
                    cos_out <= clampu(flip_reg ? -xr : xr);
                    sin_out <= clampu(flip_reg ? -yr : yr);
                    done <= 1'b1;
                    state_reg <= ST_IDLE;
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

FILE: src/dhfk_back.sv
// ----------------------------------------------------------------------------
// dhfk_back
// Runs sine/cosine, builds the local transform, updates the chain product
// on one shared multiplier and sends six rows per joint.
// ----------------------------------------------------------------------------
`default_nettype none
`include "dh_forward_kinematics_chain_core_defines.svh"
module dhfk_back
    import dhfk_pkg::*;
#(
    parameter int CORDIC_STEPS = 16
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               q_valid,
    output logic                    q_ready,
    input  wire joint_t             q_data,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic                    m_row_kind,
    output logic [1:0]              m_row_index,
    output logic                    m_last_row,
    output logic signed [31:0]      m_elem_zero,
    output logic signed [31:0]      m_elem_one,
    output logic signed [31:0]      m_elem_two,
    output logic signed [31:0]      m_elem_three
);
    typedef enum logic [2:0] {
        ST_IDLE, ST_TH, ST_AL, ST_LOCAL, ST_MAT, ST_EMIT
    } state_t;
    state_t state_reg;
    joint_t job_reg;
    logic signed [31:0] c_reg [12];
    logic signed [31:0] nc_reg [12];
    logic signed [31:0] m_reg [12];
    logic signed [31:0] st_reg, ct_reg;
    logic [3:0] step_reg;
    logic [1:0] k_reg;
    logic signed [65:0] acc_reg;
    logic [2:0] row_reg;
    logic cstart;
    logic signed [16:0] cang;
    logic cdone;
    logic signed [31:0] csin, ccos;
    logic signed [31:0] pa, pb, prod;
    logic signed [63:0] praw;
    logic [3:0] ci, mi;
    logic [1:0] ri, ji;

    dhfk_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
        .aclk(aclk), .aresetn(aresetn), .start(cstart), .angle(cang),
        .done(cdone), .sin_out(csin), .cos_out(ccos)
    );

    assign cstart = (state_reg == ST_IDLE && q_valid) || (state_reg == ST_TH && cdone);
    assign cang = (state_reg == ST_IDLE) ? q_data.theta : 17'(job_reg.alpha);
    assign q_ready = (state_reg == ST_IDLE);

    assign ri = step_reg[3:2];
    assign ji = step_reg[1:0];
    assign ci = {ri, 2'b00} + 4'(k_reg);
    assign mi = {k_reg, 2'b00} + 4'(ji);

    always_comb begin
        pa = c_reg[ci];
        pb = m_reg[mi];
        case (step_reg)
            4'd0: begin pa = st_reg; pb = m_reg[10]; end
            4'd1: begin pa = st_reg; pb = m_reg[9]; end
            4'd2: begin pa = job_reg.link_length; pb = ct_reg; end
            4'd3: begin pa = ct_reg; pb = m_reg[10]; end
            4'd4: begin pa = ct_reg; pb = m_reg[9]; end
            4'd5: begin pa = job_reg.link_length; pb = st_reg; end
            default: begin pa = '0; pb = '0; end
        endcase
        if (state_reg == ST_MAT) begin
            pa = c_reg[ci];
            pb = m_reg[mi];
        end
        praw = 64'(pa) * 64'(pb);
        prod = sat32((66'(praw) + 66'sd32768) >>> 16);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            m_valid <= 1'b0;
            for (int n = 0; n < 12; n++) begin
                c_reg[n] <= (n % 5 == 0) ? Q_ONE : 32'sd0;
            end
        end else begin
            case (state_reg)
                ST_IDLE: begin
                    if (q_valid) begin
                        job_reg <= q_data;
                        state_reg <= ST_TH;
                    end
                end
                ST_TH: begin
                    if (cdone) begin
                        st_reg <= csin;
                        ct_reg <= ccos;
                        state_reg <= ST_AL;
                    end
                end
                ST_AL: begin
                    if (cdone) begin
                        m_reg[0] <= ct_reg;
                        m_reg[4] <= st_reg;
                        m_reg[8] <= '0;
                        m_reg[9] <= csin;
                        m_reg[10] <= ccos;
                        m_reg[11] <= job_reg.link_offset;
                        step_reg <= 4'd0;
                        state_reg <= ST_LOCAL;
                    end
                end
                ST_LOCAL: begin
                    case (step_reg)
                        4'd0: m_reg[1] <= sat32(-66'(prod));
                        4'd1: m_reg[2] <= prod;
                        4'd2: m_reg[3] <= prod;
                        4'd3: m_reg[5] <= prod;
                        4'd4: m_reg[6] <= sat32(-66'(prod));
                        default: m_reg[7] <= prod;
                    endcase
                    if (step_reg == 4'd5) begin
                        step_reg <= 4'd0;
                        k_reg <= 2'd0;
                        acc_reg <= '0;
                        if (job_reg.first_joint) begin
                            for (int n = 0; n < 12; n++) begin
                                nc_reg[n] <= (n == 7) ? prod : m_reg[n];
                            end
                            row_reg <= 3'd0;
                            state_reg <= ST_EMIT;
                        end else begin
                            state_reg <= ST_MAT;
                        end
                    end else begin
                        step_reg <= step_reg + 4'd1;
                    end
                end
                ST_MAT: begin
                    if (k_reg == 2'd2) begin
                        nc_reg[step_reg] <= sat32(acc_reg + 66'(prod)
                            + ((ji == 2'd3) ? 66'(c_reg[{ri, 2'b11}]) : 66'sd0));
                        acc_reg <= '0;
                        k_reg <= 2'd0;
                        if (step_reg == 4'd11) begin
                            row_reg <= 3'd0;
                            state_reg <= ST_EMIT;
                        end else begin
                            step_reg <= step_reg + 4'd1;
                        end
                    end else begin
                        acc_reg <= acc_reg + 66'(prod);
                        k_reg <= k_reg + 2'd1;
                    end
                end
                ST_EMIT: begin
                    if (!m_valid || m_ready) begin
                        if (row_reg == 3'd6) begin
                            m_valid <= 1'b0;
                            for (int n = 0; n < 12; n++) c_reg[n] <= nc_reg[n];
                            state_reg <= ST_IDLE;
                        end else begin
                            m_valid <= 1'b1;
                            m_last_row <= (row_reg == 3'd5);
                            if (row_reg < 3'd3) begin
                                m_row_kind <= 1'b0;
                                m_row_index <= row_reg[1:0];
                                m_elem_zero  <= nc_reg[{row_reg[1:0], 2'd0}];
                                m_elem_one   <= nc_reg[{row_reg[1:0], 2'd1}];
                                m_elem_two   <= nc_reg[{row_reg[1:0], 2'd2}];
                                m_elem_three <= nc_reg[{row_reg[1:0], 2'd3}];
                            end else begin
                                m_row_kind <= 1'b1;
                                m_row_index <= 2'(row_reg - 3'd3);
                                m_elem_zero  <= m_reg[4'(row_reg - 3'd3)];
                                m_elem_one   <= m_reg[4'(row_reg - 3'd3) + 4'd4];
                                m_elem_two   <= m_reg[4'(row_reg - 3'd3) + 4'd8];
                                m_elem_three <= '0;
                            end
                            row_reg <= row_reg + 3'd1;
                        end
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    `DHFK_ASSERT_IMPL(a_out_only_emit, aclk, aresetn, m_valid, state_reg == ST_EMIT)
    `DHFK_ASSERT_IMPL(a_rot_zero, aclk, aresetn, m_valid && m_row_kind, m_elem_three == 32'sd0)
    `DHFK_ASSERT_NEXT(a_stall_hold, aclk, aresetn, m_valid && !m_ready,
        m_valid && $stable(m_row_index) && $stable(m_row_kind))
endmodule
`default_nettype wire

FILE: src/dh_forward_kinematics_chain_core.sv
// Denavit-Hartenberg forward kinematics chain core.
// Input channel s_*: one joint request per handshake (a, d, theta, home,
// alpha and a first-joint flag). Output channel m_*: six rows per joint,
// three rows of the cumulative transform, then three rows of the local
// rotation transposed; last_row marks the sixth.
// A two-entry queue stands before the compute engine, so requests are taken
// while the engine works or the receiver stalls.
// Per joint: two CORDIC runs, the local transform and the 3x4 product on
// the single shared 32x32 multiplier, then six output rows; the engine
// takes the next request from the queue only once it is back in idle.
// A first-joint request skips the product pass.
// Reset (aresetn low, synchronous) empties the queue and sets the running
// transform to identity. When m_ready is low the current row holds and the
// engine waits; the queue keeps accepting until it is full.
`default_nettype none
module dh_forward_kinematics_chain_core
    import dhfk_pkg::*;
#(
    parameter int CORDIC_STEPS = 16
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic               s_first_joint,
    input  wire logic signed [31:0] s_link_length,
    input  wire logic signed [31:0] s_link_offset,
    input  wire logic signed [15:0] s_joint_angle,
    input  wire logic signed [15:0] s_home_angle,
    input  wire logic signed [15:0] s_link_twist,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic                    m_row_kind,
    output logic [1:0]              m_row_index,
    output logic                    m_last_row,
    output logic signed [31:0]      m_elem_zero,
    output logic signed [31:0]      m_elem_one,
    output logic signed [31:0]      m_elem_two,
    output logic signed [31:0]      m_elem_three
);
    logic   q_valid, q_ready;
    joint_t q_data;

    dhfk_front u_front (
        .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
        .s_first_joint(s_first_joint), .s_link_length(s_link_length),
        .s_link_offset(s_link_offset), .s_joint_angle(s_joint_angle),
        .s_home_angle(s_home_angle), .s_link_twist(s_link_twist),
        .q_valid(q_valid), .q_ready(q_ready), .q_data(q_data)
    );

    dhfk_back #(.CORDIC_STEPS(CORDIC_STEPS)) u_back (
        .aclk(aclk), .aresetn(aresetn), .q_valid(q_valid), .q_ready(q_ready),
        .q_data(q_data), .m_valid(m_valid), .m_ready(m_ready),
        .m_row_kind(m_row_kind), .m_row_index(m_row_index),
        .m_last_row(m_last_row), .m_elem_zero(m_elem_zero),
        .m_elem_one(m_elem_one), .m_elem_two(m_elem_two),
        .m_elem_three(m_elem_three)
    );
endmodule
`default_nettype wire

FILE: verif/tb.sv
// ----------------------------------------------------------------------------
// tb: forward kinematics chain core testbench
// Sends joint requests with random gaps and checks every emitted row
// against a predictor that computes sines and cosines, the local transform
// and the running chain product in fixed point.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
module tb;
    import dhfk_pkg::*;

    localparam int STEPS = 16;

    typedef struct {
        logic        first_joint;
        logic [31:0] link_length;
        logic [31:0] link_offset;
        logic [15:0] joint_angle;
        logic [15:0] home_angle;
        logic [15:0] link_twist;
    } joint_req_t;

    typedef struct {
        logic        row_kind;
        logic [1:0]  row_index;
        logic        last_row;
        logic [31:0] elem [4];
    } row_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_first_joint = 1'b0;
    logic signed [31:0] s_link_length = '0;
    logic signed [31:0] s_link_offset = '0;
    logic signed [15:0] s_joint_angle = '0;
    logic signed [15:0] s_home_angle = '0;
    logic signed [15:0] s_link_twist = '0;
    logic m_ready = 1'b0;
    logic s_ready, m_valid, m_row_kind, m_last_row;
    logic [1:0] m_row_index;
    logic signed [31:0] m_elem_zero, m_elem_one, m_elem_two, m_elem_three;

    dh_forward_kinematics_chain_core #(.CORDIC_STEPS(STEPS)) dut (.*);

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    joint_req_t pending_joints[$];
    row_t expected_rows[$];
    logic signed [31:0] chain[12];
    int errors = 0;
    int rows_seen = 0;
    int joints_sent = 0;
    bit stimulus_done = 1'b0;

    function automatic longint floor_shift(longint v, int n);
        return v >>> n;
    endfunction

    function automatic logic signed [31:0] sat(longint v);
        if (v > 64'sd2147483647) return 32'sh7fffffff;
        if (v < -64'sd2147483648) return 32'sh80000000;
        return v[31:0];
    endfunction

    function automatic logic signed [31:0] fx_mul(logic signed [31:0] a,
                                                  logic signed [31:0] b);
        longint p;
        p = longint'(a) * longint'(b) + 32768;
        return sat(floor_shift(p, 16));
    endfunction

    function automatic logic signed [31:0] fx_neg(logic signed [31:0] a);
        return sat(-longint'(a));
    endfunction

    function automatic logic signed [31:0] unit_clamp(longint v);
        if (v > 65536) return 32'sd65536;
        if (v < -65536) return -32'sd65536;
        return v[31:0];
    endfunction

    function automatic longint arctan_step(int i);
        longint tab[10] = '{421657428, 248918915, 131521918, 66762579, 33510843,
                            16771758, 8387925, 4194219, 2097141, 1048575};
        if (i < 10) return tab[i];
        return longint'(1) << (29 - i);
    endfunction

    task automatic sin_cos(input longint ang, output logic signed [31:0] s,
                           output logic signed [31:0] c);
        longint z, x, y, t;
        bit flip;
        z = ang * 65536;
        x = 652032874;
        y = 0;
        flip = 1'b0;
        for (int i = 0; i < 4; i++) begin
            if (z > 843314856) begin
                z -= 1686629713;
                flip = !flip;
            end else if (z < -843314856) begin
                z += 1686629713;
                flip = !flip;
            end
        end
        for (int i = 0; i < STEPS; i++) begin
            if (z >= 0) begin
                t = x - (y >>> i);
                y = y + (x >>> i);
                z -= arctan_step(i);
            end else begin
                t = x + (y >>> i);
                y = y - (x >>> i);
                z += arctan_step(i);
            end
            x = t;
        end
        x = (x + 8192) >>> 14;
        y = (y + 8192) >>> 14;
        if (flip) begin
            x = -x;
            y = -y;
        end
        c = unit_clamp(x);
        s = unit_clamp(y);
    endtask

    task automatic predict_joint(input joint_req_t j);
        logic signed [31:0] st, ct, sa, ca, a;
        logic signed [31:0] m[12], nc[12];
        longint acc;
        row_t r;
        a = j.link_length;
        sin_cos(longint'($signed(j.joint_angle)) + longint'($signed(j.home_angle)),
                st, ct);
        sin_cos(longint'($signed(j.link_twist)), sa, ca);
        m[0] = ct; m[1] = fx_neg(fx_mul(st, ca)); m[2] = fx_mul(st, sa);
        m[3] = fx_mul(a, ct);
        m[4] = st; m[5] = fx_mul(ct, ca); m[6] = fx_neg(fx_mul(ct, sa));
        m[7] = fx_mul(a, st);
        m[8] = 0; m[9] = sa; m[10] = ca; m[11] = j.link_offset;
        if (j.first_joint) begin
            nc = m;
        end else begin
            for (int i = 0; i < 3; i++) begin
                for (int c = 0; c < 4; c++) begin
                    acc = (c == 3) ? longint'(chain[i*4+3]) : 0;
                    for (int k = 0; k < 3; k++) begin
                        acc += fx_mul(chain[i*4+k], m[k*4+c]);
                    end
                    nc[i*4+c] = sat(acc);
                end
            end
        end
        chain = nc;
        for (int i = 0; i < 6; i++) begin
            r.row_kind = (i >= 3);
            r.row_index = 2'(i % 3);
            r.last_row = (i == 5);
            for (int c = 0; c < 4; c++) begin
                if (i < 3) r.elem[c] = nc[(i%3)*4+c];
                else r.elem[c] = (c == 3) ? 32'd0 : m[c*4+i%3];
            end
            expected_rows.push_back(r);
        end
    endtask

    function automatic logic [15:0] pick_angle();
        case ($urandom_range(0, 5))
            0: return 16'h7fff;
            1: return 16'h8000;
            2: return 16'($urandom_range(0, 12868) - 6434);
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [31:0] pick_length();
        case ($urandom_range(0, 5))
            0: return 32'h7fffffff;
            1: return 32'h80000000;
            2: return $urandom;
            default: return $urandom_range(0, 32'h00100000) - 32'h00080000;
        endcase
    endfunction

    task automatic queue_joint(input bit f, input logic [31:0] a, input logic [31:0] d,
                               input logic [15:0] t, input logic [15:0] h,
                               input logic [15:0] al);
        joint_req_t j;
        j.first_joint = f; j.link_length = a; j.link_offset = d;
        j.joint_angle = t; j.home_angle = h; j.link_twist = al;
        pending_joints.push_back(j);
    endtask

    initial begin
        for (int i = 0; i < 12; i++) chain[i] = (i % 5 == 0) ? 32'sd65536 : 32'sd0;
        queue_joint(0, 32'h00010000, 32'h00020000, 16'd0, 16'd0, 16'd0);
        queue_joint(0, 32'h7fffffff, 32'h80000000, 16'h7fff, 16'h7fff, 16'h7fff);
        queue_joint(0, 32'h80000000, 32'h7fffffff, 16'h8000, 16'h8000, 16'h8000);
        queue_joint(1, 32'h7fffffff, 32'h7fffffff, 16'd12868, 16'd0, 16'd12868);
        queue_joint(0, 32'h7fffffff, 32'h7fffffff, 16'd6434, 16'd6434, 16'hcdbc);
        queue_joint(0, 32'hffffffff, 32'h00000000, 16'hcdbc, 16'd0, 16'd6434);
        queue_joint(1, 32'h00000000, 32'hffffffff, 16'd25736, 16'd0, 16'd25736);
        queue_joint(0, 32'h00050000, 32'hfffb0000, 16'd3217, 16'hf36f, 16'd0);
        queue_joint(1, 32'h12345678, 32'hedcba987, 16'hffff, 16'h0001, 16'h5555);
        queue_joint(0, 32'haaaaaaaa, 32'h55555555, 16'haaaa, 16'h5555, 16'haaaa);
        for (int n = 0; n < 300; n++) begin
            queue_joint($urandom_range(0, 5) == 0, pick_length(), pick_length(),
                        pick_angle(), pick_angle(), pick_angle());
        end
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
    end

    // The valid/ready pair is sampled by value captured at the rising edge.
    logic s_take, m_take;
    always @(posedge aclk) begin
        s_take <= s_valid && s_ready;
        m_take <= m_valid && m_ready;
    end

    int send_gap = 0;
    always @(negedge aclk) begin
        if (aresetn) begin
            if (s_take) begin
                predict_joint(pending_joints.pop_front());
                joints_sent++;
                send_gap = $urandom_range(0, 14);
                if ($urandom_range(0, 3) == 0) send_gap = 0;
                if (send_gap == 0 && pending_joints.size() > 0) begin
                    s_first_joint <= pending_joints[0].first_joint;
                    s_link_length <= pending_joints[0].link_length;
                    s_link_offset <= pending_joints[0].link_offset;
                    s_joint_angle <= pending_joints[0].joint_angle;
                    s_home_angle <= pending_joints[0].home_angle;
                    s_link_twist <= pending_joints[0].link_twist;
                end else begin
                    s_valid <= 1'b0;
                end
                if (pending_joints.size() == 0) stimulus_done = 1'b1;
            end else if (!s_valid && pending_joints.size() > 0) begin
                if (send_gap > 0) begin
                    send_gap--;
                end else begin
                    s_valid <= 1'b1;
                    s_first_joint <= pending_joints[0].first_joint;
                    s_link_length <= pending_joints[0].link_length;
                    s_link_offset <= pending_joints[0].link_offset;
                    s_joint_angle <= pending_joints[0].joint_angle;
                    s_home_angle <= pending_joints[0].home_angle;
                    s_link_twist <= pending_joints[0].link_twist;
                end
            end
        end
    end

    int stall = 0;
    always @(negedge aclk) begin
        if (aresetn) begin
            if (stall > 0) begin
                stall--;
                m_ready <= 1'b0;
            end else if (m_take) begin
                stall = $urandom_range(0, 14);
                m_ready <= (stall == 0);
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        row_t e;
        logic [31:0] got[4];
        if (aresetn && m_valid && m_ready) begin
            rows_seen++;
            got = '{m_elem_zero, m_elem_one, m_elem_two, m_elem_three};
            if (expected_rows.size() == 0) begin
                $error("unexpected row: kind %0d index %0d", m_row_kind, m_row_index);
                errors++;
            end else begin
                e = expected_rows.pop_front();
                if (m_row_kind !== e.row_kind) begin
                    $error("row_kind expected %0d actual %0d", e.row_kind, m_row_kind);
                    errors++;
                end
                if (m_row_index !== e.row_index) begin
                    $error("row_index expected %0d actual %0d", e.row_index, m_row_index);
                    errors++;
                end
                if (m_last_row !== e.last_row) begin
                    $error("last_row expected %0d actual %0d", e.last_row, m_last_row);
                    errors++;
                end
                for (int c = 0; c < 4; c++) begin
                    if (got[c] !== e.elem[c]) begin
                        $error("elem column %0d expected %0d actual %0d", c,
                               $signed(e.elem[c]), $signed(got[c]));
                        errors++;
                    end
                end
            end
        end
    end

    initial begin
        wait (stimulus_done);
        while (expected_rows.size() > 0) @(posedge aclk);
        repeat (200) @(posedge aclk);
        $display("Sent %0d joint requests, checked %0d rows.", joints_sent, rows_seen);
        if (errors == 0 && expected_rows.size() == 0) begin
            $display("tb OK");
        end else begin
            $display("tb NOT OK");
        end
        $finish;
    end

    initial begin
        #5ms;
        $display("tb NOT OK");
        $finish;
    end
endmodule
